// ===== rtl/pac_pkg.sv =====
package pac_pkg;

   // Fixed field widths
   localparam int ID_W    = 8;
   localparam int MASK_W  = 8;
   localparam int SIZE_W  = 11;
   localparam int AREA_W  = 20;
   localparam int PERIM_W = 22;
   localparam int PORE_W  = 21;

   // Phase ids at or above this limit are never selected
   localparam int PHASE_BITS = 8;
   localparam int SEL_LIMIT  = (PHASE_BITS < MASK_W) ? PHASE_BITS : MASK_W;
   localparam int MASK_IDX_W = $clog2(MASK_W);

   // Default line store depth
   localparam int MAX_LINE_DEF = 1024;

   // Per-pixel flags: bit 0 pore, bit 1 selected
   localparam int FLAG_W    = 2;
   localparam int FLAG_PORE = 0;
   localparam int FLAG_SEL  = 1;

   // One window column holds three rows of flags: up, middle, current
   localparam int COL_FLAGS_W = 3 * FLAG_W;
   localparam int WIN_COLS    = 3;

   // Reset values of the control registers
   localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
   localparam int SIZE_MIN = 3;

   // Control register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_MASK = 2'd0,
      CSR_ROW_COUNT  = 2'd1,
      CSR_ROW_LENGTH = 2'd2
   } csr_index_type;

   // Shift / clear control for the window cells
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// ===== rtl/pac_req_if.sv =====
interface pac_req_if;
   logic                     valid;
   logic                     ready;
   logic [pac_pkg::ID_W-1:0] phase_id;

   modport source (output valid, output phase_id, input ready);
   modport sink   (input valid, input phase_id, output ready);
endinterface

// ===== rtl/pac_rsp_if.sv =====
interface pac_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pac_pkg::AREA_W-1:0]  area_count;
   logic [pac_pkg::PERIM_W-1:0] perimeter_count;
   logic [pac_pkg::PORE_W-1:0]  pore_count;

   modport source (output valid, output area_count, output perimeter_count,
                   output pore_count, input ready);
   modport sink   (input valid, input area_count, input perimeter_count,
                   input pore_count, output ready);
endinterface

// ===== rtl/pac_ram.sv =====
module pac_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pac_cell.sv =====
module pac_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  pac_pkg::cell_ctrl_type             ctrl,
   input  logic [pac_pkg::COL_FLAGS_W-1:0]    din,
   output logic [pac_pkg::COL_FLAGS_W-1:0]    q
);

   logic [pac_pkg::COL_FLAGS_W-1:0] col_ff;
   logic [pac_pkg::COL_FLAGS_W-1:0] col_in;

   // On a shift, take the neighbor's column, or empty at the end of a row; otherwise hold
   always_comb begin
      col_in = col_ff;
      if (ctrl.shift) begin
         col_in = ctrl.clear ? '0 : din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign q = col_ff;

endmodule

// ===== rtl/phase_area_perimeter_counter.sv =====
// Area and 4-neighbor perimeter counter for a phase image.
// req_chan: one phase-id pixel per request, raster order, row by row.
// rsp_chan: one result per frame (area, perimeter, pore count), issued
//   for the last pixel of the frame.
// csr_*: write-only control registers (phase mask, rows, row length),
//   written while the block is idle (the user's duty; the block does not
//   enforce it); sizes are clamped to 3..MAX_LINE.
// Throughput: one pixel per clock while req_chan.ready is high (see below).
//   The line store is read at the edge that accepts a pixel, which then
//   enters the window stage; a frame's result is registered from there.
// A pending result does not stop the stream: ready drops only for the
//   last pixel of the next frame while the previous result is still
//   held by the receiver.
// Reset clears position, window and totals and loads the register
//   defaults; the line stores are not cleared, as what a frame's first
//   two rows read from them never reaches the counts.
module phase_area_perimeter_counter #(
   parameter int MAX_LINE = pac_pkg::MAX_LINE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pac_req_if.sink                       req_chan,
   pac_rsp_if.source                     rsp_chan,
   input  logic                          csr_write,
   input  pac_pkg::csr_index_type        csr_index,
   input  logic [pac_pkg::SIZE_W-1:0]    csr_data
);

   localparam int CNT_W  = $clog2(MAX_LINE);
   localparam int CMP_W  = ((CNT_W + 1 > pac_pkg::SIZE_W) ? CNT_W + 1 : pac_pkg::SIZE_W) + 1;
   localparam int LINE_W = 2 * pac_pkg::FLAG_W;

   // Control registers
   logic [pac_pkg::MASK_W-1:0] mask_ff;
   logic [pac_pkg::SIZE_W-1:0] rows_ff;
   logic [pac_pkg::SIZE_W-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= pac_pkg::MASK_RESET;
         rows_ff <= pac_pkg::SIZE_RESET;
         len_ff  <= pac_pkg::SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            pac_pkg::CSR_PHASE_MASK: mask_ff <= csr_data[pac_pkg::MASK_W-1:0];
            pac_pkg::CSR_ROW_COUNT:  rows_ff <= csr_data;
            pac_pkg::CSR_ROW_LENGTH: len_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp sizes into 3..MAX_LINE
   logic [CMP_W-1:0] rows_ext, len_ext, rows_lim, len_lim;

   always_comb begin
      rows_ext = CMP_W'(rows_ff);
      len_ext  = CMP_W'(len_ff);
      if (rows_ext < CMP_W'(pac_pkg::SIZE_MIN)) begin
         rows_lim = CMP_W'(pac_pkg::SIZE_MIN);
      end else if (rows_ext > CMP_W'(MAX_LINE)) begin
         rows_lim = CMP_W'(MAX_LINE);
      end else begin
         rows_lim = rows_ext;
      end
      if (len_ext < CMP_W'(pac_pkg::SIZE_MIN)) begin
         len_lim = CMP_W'(pac_pkg::SIZE_MIN);
      end else if (len_ext > CMP_W'(MAX_LINE)) begin
         len_lim = CMP_W'(MAX_LINE);
      end else begin
         len_lim = len_ext;
      end
   end

   // Entry stage: position, frame boundaries and pixel flags
   logic [CNT_W-1:0]           col_ff, row_ff;
   logic [CMP_W-1:0]           col_next, row_next;
   logic                       s0_row_end, s0_frame_end, s0_interior;
   logic [pac_pkg::FLAG_W-1:0] s0_flags;
   logic                       req_accept;
   logic                       rsp_valid_ff;

   always_comb begin
      col_next     = CMP_W'(col_ff) + CMP_W'(1);
      row_next     = CMP_W'(row_ff) + CMP_W'(1);
      s0_row_end   = (col_next >= len_lim);
      s0_frame_end = s0_row_end && (row_next >= rows_lim);
      s0_interior  = (CMP_W'(col_ff) >= CMP_W'(2)) && (CMP_W'(row_ff) >= CMP_W'(2))
                     && (col_next <= len_lim) && (row_next <= rows_lim);
      s0_flags[pac_pkg::FLAG_PORE] = (req_chan.phase_id == '0);
      s0_flags[pac_pkg::FLAG_SEL]  =
         (req_chan.phase_id < pac_pkg::ID_W'(pac_pkg::SEL_LIMIT))
         && mask_ff[req_chan.phase_id[pac_pkg::MASK_IDX_W-1:0]];
   end

   // Hold back only a frame's last pixel while the last result is still unread
   assign req_chan.ready = !(s0_frame_end && rsp_valid_ff && !rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (s0_row_end) begin
            col_ff <= '0;
         end else begin
            col_ff <= col_next[CNT_W-1:0];
         end
         if (s0_frame_end) begin
            row_ff <= '0;
         end else if (s0_row_end) begin
            row_ff <= row_next[CNT_W-1:0];
         end
      end
   end

   // Window stage registers
   logic                       s1_valid_ff;
   logic                       s1_row_end_ff, s1_frame_end_ff, s1_interior_ff;
   logic [pac_pkg::FLAG_W-1:0] s1_flags_ff;
   logic [CNT_W-1:0]           s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_end_ff   <= s0_row_end;
         s1_frame_end_ff <= s0_frame_end;
         s1_interior_ff  <= s0_interior;
         s1_flags_ff     <= s0_flags;
         s1_col_ff       <= col_ff;
      end
   end

   // Line store: {newer row, older row} flags per column
   logic [LINE_W-1:0]          line_rd;
   logic [pac_pkg::FLAG_W-1:0] up_flags, mid_flags;

   assign up_flags  = line_rd[pac_pkg::FLAG_W-1:0];
   assign mid_flags = line_rd[LINE_W-1:pac_pkg::FLAG_W];

   pac_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_LINE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_flags_ff, mid_flags}),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // Row of window cells: cell 0 oldest column, new column enters the last
   logic [pac_pkg::COL_FLAGS_W-1:0] new_col;
   logic [pac_pkg::COL_FLAGS_W-1:0] cell_q [pac_pkg::WIN_COLS];
   pac_pkg::cell_ctrl_type          cell_ctrl;

   assign new_col         = {s1_flags_ff, mid_flags, up_flags};
   assign cell_ctrl.shift = s1_valid_ff;
   assign cell_ctrl.clear = s1_row_end_ff;

   for (genvar k = 0; k < pac_pkg::WIN_COLS; k++) begin : g_cell
      pac_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (cell_ctrl),
         .din   ((k == pac_pkg::WIN_COLS - 1) ? new_col : cell_q[(k + 1) % pac_pkg::WIN_COLS]),
         .q     (cell_q[k])
      );
   end

   // Centre after the shift is the old last cell; left is the old middle cell
   logic [pac_pkg::COL_FLAGS_W-1:0] centre_col, left_col;
   logic                            count_en;
   logic [2:0]                      edges;

   always_comb begin
      centre_col = cell_q[pac_pkg::WIN_COLS-1];
      left_col   = cell_q[pac_pkg::WIN_COLS-2];
      count_en   = s1_valid_ff && s1_interior_ff
                   && centre_col[pac_pkg::FLAG_W + pac_pkg::FLAG_SEL];
      edges      = 3'(centre_col[pac_pkg::FLAG_PORE])
                 + 3'(centre_col[2*pac_pkg::FLAG_W + pac_pkg::FLAG_PORE])
                 + 3'(left_col[pac_pkg::FLAG_W + pac_pkg::FLAG_PORE])
                 + 3'(new_col[pac_pkg::FLAG_W + pac_pkg::FLAG_PORE]);
   end

   // Frame totals
   logic [pac_pkg::AREA_W-1:0]  area_ff, area_in;
   logic [pac_pkg::PERIM_W-1:0] perim_ff, perim_in;
   logic [pac_pkg::PORE_W-1:0]  pore_ff, pore_in;

   always_comb begin
      area_in  = area_ff;
      perim_in = perim_ff;
      pore_in  = pore_ff;
      if (count_en) begin
         area_in  = area_ff + pac_pkg::AREA_W'(1);
         perim_in = perim_ff + pac_pkg::PERIM_W'(edges);
      end
      if (s1_valid_ff && s1_flags_ff[pac_pkg::FLAG_PORE]) begin
         pore_in = pore_ff + pac_pkg::PORE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff  <= '0;
         perim_ff <= '0;
         pore_ff  <= '0;
      end else if (s1_valid_ff && s1_frame_end_ff) begin
         area_ff  <= '0;
         perim_ff <= '0;
         pore_ff  <= '0;
      end else begin
         area_ff  <= area_in;
         perim_ff <= perim_in;
         pore_ff  <= pore_in;
      end
   end

   // Result register
   logic [pac_pkg::AREA_W-1:0]  rsp_area_ff;
   logic [pac_pkg::PERIM_W-1:0] rsp_perim_ff;
   logic [pac_pkg::PORE_W-1:0]  rsp_pore_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_frame_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_frame_end_ff) begin
         rsp_area_ff  <= area_in;
         rsp_perim_ff <= perim_in;
         rsp_pore_ff  <= pore_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.area_count      = rsp_area_ff;
   assign rsp_chan.perimeter_count = rsp_perim_ff;
   assign rsp_chan.pore_count      = rsp_pore_ff;

   // A frame result never lands on an unread one
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_frame_end_ff) |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("frame result overwrote a pending result");

   // The column wraps to zero after the last pixel of a row
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && s0_row_end) |=> (col_ff == '0))
      else $error("column did not wrap at row end");

   // A result appears only after a frame's last pixel leaves the window stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_frame_end_ff))
      else $error("result without a finished frame");

endmodule
